@@ hdl/indexed_insert_erase_array_core_defines.svh @@
// Assertion macros used by the checker file of this block.
`ifndef INDEXED_INSERT_ERASE_ARRAY_CORE_DEFINES_SVH
`define INDEXED_INSERT_ERASE_ARRAY_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define IIEA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("iiea port check failed");

// Next-cycle implication, sampled on the block clock, off during reset.
`define IIEA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("iiea port check failed");

`endif

@@ hdl/iiea_pkg.sv @@
package iiea_pkg;

   localparam int DEPTH     = 256;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int WORD_W    = 32;
   localparam int POS_W     = 9;
   localparam int CAP_W     = 10;

   typedef enum logic [1:0] {
      OP_INSERT    = 2'd0,
      OP_ERASE     = 2'd1,
      OP_READ      = 2'd2,
      OP_OVERWRITE = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type               opcode;
      logic [POS_W-1:0]         position;
      logic signed [WORD_W-1:0] word;
      logic [POS_W-1:0]         count;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] read_word;
      logic [POS_W-1:0]         length;
      logic [CAP_W-1:0]         capacity_figure;
      logic                     fault;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_WALK
   } state_type;

   typedef struct packed {
      logic capture;
      logic rd_issue;
      logic init;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic       fault;
      opcode_type opcode;
      logic       walk_done;
   } status_type;

endpackage

@@ hdl/iiea_ram.sv @@
module iiea_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      rdata_ff <= store_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/iiea_ctrl.sv @@
module iiea_ctrl
   import iiea_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   output logic       rsp_strobe,
   output cmd_type    cmd,
   input  status_type status
);

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.fault || status.opcode == OP_OVERWRITE) begin
               state_in = ST_IDLE;
            end else if (status.opcode == OP_READ) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         ST_WALK: begin
            if (status.walk_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = start;
         end
         ST_CHECK: begin
            if (status.fault || status.opcode == OP_OVERWRITE) begin
               cmd.finish = 1'b1;
            end else if (status.opcode == OP_READ) begin
               cmd.rd_issue = 1'b1;
            end else begin
               cmd.init = 1'b1;
            end
         end
         ST_READ: begin
            cmd.finish = 1'b1;
         end
         ST_WALK: begin
            cmd.step   = 1'b1;
            cmd.finish = status.walk_done;
         end
         default: cmd = '0;
      endcase
   end

   assign strobe_in  = cmd.finish;
   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

@@ hdl/iiea_dpath.sv @@
module iiea_dpath
   import iiea_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output rsp_type    rsp_data
);

   req_type           req_ff;
   logic [POS_W-1:0]  count_ff, count_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [POS_W-1:0]  idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   rsp_type           rsp_ff, rsp_in;

   logic              fault;
   logic              more;
   logic              is_insert;
   logic [POS_W:0]    pos_plus_cnt;
   logic [POS_W:0]    idx_plus_cnt;
   logic [POS_W-1:0]  grown;
   logic              apply;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [WORD_W-1:0] ram_rdata;

   assign is_insert    = (req_ff.opcode == OP_INSERT);
   assign pos_plus_cnt = {1'b0, req_ff.position} + {1'b0, req_ff.count};
   assign idx_plus_cnt = {1'b0, idx_ff} + {1'b0, req_ff.count};
   assign grown        = count_ff + POS_W'(1);

   always_comb begin
      unique case (req_ff.opcode)
         OP_INSERT: fault = (count_ff == POS_W'(DEPTH)) || (req_ff.position > count_ff);
         OP_ERASE:  fault = pos_plus_cnt > {1'b0, count_ff};
         default:   fault = (req_ff.position >= count_ff);
      endcase
   end

   // Insert walks down from the end, erase walks up from the position.
   always_comb begin
      if (is_insert) begin
         more = (idx_ff > req_ff.position);
      end else begin
         more = (req_ff.count != '0) && (idx_plus_cnt < {1'b0, count_ff});
      end
   end

   assign status.fault     = fault;
   assign status.opcode    = req_ff.opcode;
   assign status.walk_done = !more && !pend_ff;

   assign apply = cmd.finish && !fault;

   always_comb begin
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      if (cmd.init) begin
         idx_in  = is_insert ? count_ff : req_ff.position;
         pend_in = 1'b0;
      end else if (cmd.step) begin
         pend_in = more;
         if (more) begin
            pend_addr_in = idx_ff[ADDR_W-1:0];
            idx_in       = is_insert ? (idx_ff - POS_W'(1)) : (idx_ff + POS_W'(1));
         end
      end
   end

   always_comb begin
      ram_raddr = req_ff.position[ADDR_W-1:0];
      if (cmd.step) begin
         ram_raddr = is_insert ? ADDR_W'(idx_ff - POS_W'(1)) : idx_plus_cnt[ADDR_W-1:0];
      end
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = pend_addr_ff;
      ram_wdata = ram_rdata;
      if (apply && (req_ff.opcode == OP_INSERT || req_ff.opcode == OP_OVERWRITE)) begin
         ram_we    = 1'b1;
         ram_waddr = req_ff.position[ADDR_W-1:0];
         ram_wdata = req_ff.word;
      end else if (cmd.step && pend_ff) begin
         ram_we = 1'b1;
      end
   end

   always_comb begin
      count_in = count_ff;
      cap_in   = cap_ff;
      if (apply) begin
         if (req_ff.opcode == OP_INSERT) begin
            count_in = grown;
            // Capacity was above the old size, so one doubling is always enough.
            if (cap_ff <= CAP_W'(grown)) begin
               cap_in = {cap_ff[CAP_W-2:0], 1'b0};
            end
         end else if (req_ff.opcode == OP_ERASE) begin
            count_in = count_ff - req_ff.count;
         end
      end
   end

   always_comb begin
      rsp_in                 = rsp_ff;
      rsp_in.read_word       = (apply && req_ff.opcode == OP_READ) ? ram_rdata : '0;
      rsp_in.length          = count_in;
      rsp_in.capacity_figure = cap_in;
      rsp_in.fault           = fault;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= CAP_W'(1);
         pend_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         cap_ff   <= cap_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
      idx_ff       <= idx_in;
      pend_addr_ff <= pend_addr_in;
   end

   iiea_ram #(
      .WIDTH(WORD_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign rsp_data = rsp_ff;

endmodule

@@ hdl/indexed_insert_erase_array_core.sv @@
// Ordered list of signed 32-bit words in a 256-entry store.
// A request word is taken at a rising edge with start high and busy low;
// busy then stays high until the item is done. Opcodes: insert, erase,
// read and overwrite at a list position.
// Every item gives one response word on rsp_data, valid for exactly one
// cycle while rsp_strobe is high. The receiver cannot stall, so the word is
// simply presented; start may be raised again in that same cycle.
// A faulted item or an overwrite finishes from the check state, a read passes
// through the read state, and insert or erase pass through the walk state,
// which moves n entries (up to 255); an insert or erase may move no entry.
// The move loop copies one entry per cycle through the single-write,
// registered-read port of the store.
// Synchronous reset empties the list and sets capacity to one; store contents
// are not cleared, since only entries below the current length are read.
module indexed_insert_erase_array_core
   import iiea_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   iiea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_strobe(rsp_strobe),
      .cmd       (cmd),
      .status    (status)
   );

   iiea_dpath u_dpath (
      .clock   (clock),
      .reset   (reset),
      .req_data(req_data),
      .cmd     (cmd),
      .status  (status),
      .rsp_data(rsp_data)
   );

endmodule

@@ hdl/iiea_checker.sv @@
`include "indexed_insert_erase_array_core_defines.svh"

module iiea_checker
   import iiea_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // An accepted word always occupies the block for at least the next cycle.
   `IIEA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

   // The response arrives only once the block has gone idle.
   `IIEA_ASSERT_NOW(a_strobe_idle, rsp_strobe, !busy)

   `IIEA_ASSERT_NEXT(a_strobe_single, rsp_strobe, !rsp_strobe)

   // A faulted item never returns data.
   `IIEA_ASSERT_NOW(a_fault_zero, rsp_strobe && rsp_data.fault, rsp_data.read_word == '0)

   `IIEA_ASSERT_NOW(a_cap_above_len, rsp_strobe,
      rsp_data.capacity_figure > {1'b0, rsp_data.length})

endmodule

bind indexed_insert_erase_array_core iiea_checker u_iiea_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_strobe(rsp_strobe),
   .rsp_data  (rsp_data)
);

@@ tb/indexed_insert_erase_array_core_test.sv @@
`timescale 1ns / 1ps

module indexed_insert_erase_array_core_test;
   import iiea_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // Shadow copy of the list, updated as each request word is accepted.
   logic signed [WORD_W-1:0] list_words [DEPTH];
   int list_length   = 0;
   int list_capacity = 1;

   rsp_type pending_results [$];

   int  mismatch_count  = 0;
   int  words_sent      = 0;
   int  results_checked = 0;
   int  faults_seen     = 0;
   int  cycle_count     = 0;
   bit  gaps_on         = 1'b1;

   indexed_insert_erase_array_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one request word to the shadow list and returns the response it should give.
   function automatic rsp_type apply_list_op(req_type w);
      rsp_type r;
      int      p;
      int      c;
      int      i;
      r = '0;
      p = w.position;
      c = w.count;
      case (w.opcode)
         OP_INSERT: begin
            if (list_length >= DEPTH || p > list_length) begin
               r.fault = 1'b1;
            end else begin
               for (i = list_length; i > p; i--) list_words[i] = list_words[i-1];
               list_words[p] = w.word;
               list_length++;
               while (list_capacity <= list_length) list_capacity <<= 1;
            end
         end
         OP_ERASE: begin
            if (p + c > list_length) begin
               r.fault = 1'b1;
            end else begin
               for (i = p; i + c < list_length; i++) list_words[i] = list_words[i+c];
               list_length -= c;
            end
         end
         OP_READ: begin
            if (p >= list_length) r.fault = 1'b1;
            else r.read_word = list_words[p];
         end
         default: begin
            if (p >= list_length) r.fault = 1'b1;
            else list_words[p] = w.word;
         end
      endcase
      r.length          = POS_W'(list_length);
      r.capacity_figure = CAP_W'(list_capacity);
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Start stays high from one word to the next when there is no gap between them.
   task automatic send_word(opcode_type op, int pos, logic [WORD_W-1:0] value, int cnt);
      req_type w;
      int      gap;
      w.opcode   = op;
      w.position = POS_W'(pos);
      w.word     = value;
      w.count    = POS_W'(cnt);
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) begin
            req_data <= req_type'({$urandom, $urandom});
            @(negedge clock);
         end
      end
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      pending_results.push_back(apply_list_op(w));
      words_sent++;
   endtask

   task automatic check_result(rsp_type got);
      rsp_type want;
      if (pending_results.size() == 0) begin
         $display("%0t: response word with none expected, actual %p", $time, got);
         mismatch_count++;
      end else begin
         want = pending_results.pop_front();
         results_checked++;
         if (got.fault) faults_seen++;
         if (got.read_word !== want.read_word) begin
            $display("%0t: read_word expected %0d actual %0d", $time,
                     want.read_word, got.read_word);
            mismatch_count++;
         end
         if (got.length !== want.length) begin
            $display("%0t: length expected %0d actual %0d", $time, want.length, got.length);
            mismatch_count++;
         end
         if (got.capacity_figure !== want.capacity_figure) begin
            $display("%0t: capacity_figure expected %0d actual %0d", $time,
                     want.capacity_figure, got.capacity_figure);
            mismatch_count++;
         end
         if (got.fault !== want.fault) begin
            $display("%0t: fault expected %0b actual %0b", $time, want.fault, got.fault);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d responses outstanding", $time,
                  pending_results.size());
         $display("Mismatches found");
         $finish;
      end else if (!reset && rsp_strobe) begin
         check_result(rsp_data);
      end
   end

   task automatic test_empty_list();
      send_word(OP_READ, 0, 32'h0, 0);
      send_word(OP_OVERWRITE, 0, 32'h1234_5678, 0);
      send_word(OP_ERASE, 0, 32'h0, 0);
      send_word(OP_ERASE, 0, 32'h0, 1);
      send_word(OP_INSERT, 1, 32'hDEAD_BEEF, 1);
      send_word(OP_ERASE, 511, $urandom, 511);
      send_word(OP_READ, 511, $urandom, 511);
   endtask

   task automatic test_basic_ops();
      int i;
      send_word(OP_INSERT, 0, 32'h7FFF_FFFF, 5);
      send_word(OP_INSERT, 1, 32'h8000_0000, 5);
      send_word(OP_INSERT, 0, 32'hFFFF_FFFF, 5);
      send_word(OP_INSERT, 1, 32'h0000_0000, 5);
      send_word(OP_INSERT, 4, 32'h0000_0001, 5);
      for (i = 0; i < 5; i++) send_word(OP_READ, i, 32'h0, 0);
      send_word(OP_OVERWRITE, 2, 32'h55AA_55AA, 0);
      send_word(OP_READ, 2, 32'h0, 0);
      send_word(OP_OVERWRITE, 4, 32'hAA55_AA55, 0);
      send_word(OP_READ, 5, 32'h0, 0);
      send_word(OP_ERASE, 1, 32'h0, 0);
      send_word(OP_ERASE, 1, 32'h0, 2);
      send_word(OP_READ, 1, 32'h0, 0);
      send_word(OP_ERASE, 0, 32'h0, 3);
      send_word(OP_READ, 0, 32'h0, 0);
   endtask

   task automatic test_fill_to_full();
      int pos;
      int r;
      while (list_length < DEPTH) begin
         r = $urandom_range(0, 2);
         if (r == 0) pos = list_length;
         else if (r == 1) pos = 0;
         else pos = $urandom_range(0, list_length);
         send_word(OP_INSERT, pos, $urandom, $urandom_range(0, 511));
      end
   endtask

   task automatic test_full_store();
      send_word(OP_INSERT, 0, $urandom, 1);
      send_word(OP_INSERT, 256, $urandom, 1);
      send_word(OP_READ, 255, 32'h0, 0);
      send_word(OP_READ, 256, 32'h0, 0);
      send_word(OP_OVERWRITE, 255, $urandom, 0);
      send_word(OP_READ, 255, 32'h0, 0);
      send_word(OP_ERASE, 256, 32'h0, 0);
      send_word(OP_ERASE, 0, 32'h0, 257);
      // Front erase and front insert move every entry: the slowest items.
      send_word(OP_ERASE, 0, 32'h0, 1);
      send_word(OP_INSERT, 0, $urandom, 1);
      send_word(OP_READ, 0, 32'h0, 0);
      send_word(OP_ERASE, 200, 32'h0, 56);
      send_word(OP_ERASE, 10, 32'h0, 170);
   endtask

   task automatic test_random_mix(int n_items);
      int k;
      int r;
      int pos;
      int cnt_hi;
      for (k = 0; k < n_items; k++) begin
         gaps_on = !(k >= n_items / 3 && k < n_items / 2);
         r = $urandom_range(0, 99);
         if (r < 8) begin
            send_word(opcode_type'($urandom_range(0, 3)), $urandom_range(0, 511), $urandom,
                      $urandom_range(0, 511));
         end else if (r < 40) begin
            send_word(OP_INSERT, $urandom_range(0, list_length), $urandom,
                      $urandom_range(0, 511));
         end else if (r < 55) begin
            if (list_length == 0) begin
               send_word(OP_ERASE, 0, $urandom, 0);
            end else begin
               pos    = $urandom_range(0, list_length - 1);
               cnt_hi = list_length - pos;
               if (cnt_hi > 4 && $urandom_range(0, 9) != 0) cnt_hi = 4;
               send_word(OP_ERASE, pos, $urandom, $urandom_range(0, cnt_hi));
            end
         end else begin
            pos = (list_length == 0) ? 0 : $urandom_range(0, list_length - 1);
            send_word((r < 80) ? OP_READ : OP_OVERWRITE, pos, $urandom,
                      $urandom_range(0, 511));
         end
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_basic_ops();
      test_fill_to_full();
      test_full_store();
      test_random_mix(170);

      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d request words across empty, growing, full and mixed list states.",
               words_sent);
      $display("Checked %0d response words, %0d of them with the fault flag set.",
               results_checked, faults_seen);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
